[rtl/lfp_pkg.sv]
`default_nettype none
package lfp_pkg;

	localparam logic [7:0] HDR_BYTE    = 8'h59;
	localparam logic [7:0] LIMIT_RESET = 8'd90;
	localparam logic [2:0] BODY_LAST   = 3'd6;
	localparam logic [2:0] POS_LOW     = 3'd0;
	localparam logic [2:0] POS_HIGH    = 3'd1;

	typedef enum logic [2:0] {
		PH_HUNT1 = 3'b001,
		PH_HUNT2 = 3'b010,
		PH_BODY  = 3'b100
	} phase_t;

	typedef struct packed {
		logic        done;
		logic [15:0] distance;
	} frame_t;

	// exact for 8-bit values: floor(a * 57 / 512) == floor(a / 9)
	function automatic logic is_mult9(input logic [7:0] a);
		logic [13:0] prod;
		logic [4:0]  quo;
		logic [7:0]  back;
		prod = {6'd0, a} * 14'd57;
		quo  = prod[13:9];
		back = 8'({3'd0, quo} * 8'd9);
		return back == a;
	endfunction

endpackage
`default_nettype wire

[rtl/lfp_frame_parser.sv]
`default_nettype none
module lfp_frame_parser
	import lfp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       advance,
	input  wire logic [7:0] rx_byte,
	output frame_t          frame
);

	phase_t     phase_q;
	logic [2:0] pos_q;
	logic [7:0] sum_q;
	logic [7:0] dist_low_q;
	logic [7:0] dist_high_q;

	always_comb begin
		frame.done     = (phase_q == PH_BODY) && (pos_q == BODY_LAST) && (rx_byte == sum_q);
		frame.distance = {dist_high_q, dist_low_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT1;
			pos_q       <= '0;
			sum_q       <= '0;
			dist_low_q  <= '0;
			dist_high_q <= '0;
		end else if (advance) begin
			case (phase_q)
				PH_HUNT1: begin
					if (rx_byte == HDR_BYTE) begin
						phase_q <= PH_HUNT2;
						sum_q   <= HDR_BYTE;
					end
				end
				PH_HUNT2: begin
					if (rx_byte == HDR_BYTE) begin
						phase_q <= PH_BODY;
						pos_q   <= '0;
						sum_q   <= sum_q + HDR_BYTE;
					end else begin
						phase_q <= PH_HUNT1;
						pos_q   <= '0;
						sum_q   <= '0;
					end
				end
				PH_BODY: begin
					if (pos_q < BODY_LAST) begin
						if (pos_q == POS_LOW) begin
							dist_low_q <= rx_byte;
						end
						if (pos_q == POS_HIGH) begin
							dist_high_q <= rx_byte;
						end
						sum_q <= sum_q + rx_byte;
						pos_q <= pos_q + 3'd1;
					end else begin
						phase_q <= PH_HUNT1;
						pos_q   <= '0;
						sum_q   <= '0;
					end
				end
				default: begin
					phase_q <= PH_HUNT1;
					pos_q   <= '0;
					sum_q   <= '0;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/lfp_sweep.sv]
`default_nettype none
module lfp_sweep
	import lfp_pkg::*;
#(
	parameter int SLOTS = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     advance,
	input  wire logic                     frame_done,
	input  wire logic [7:0]               scan_angle,
	input  wire logic [7:0]               sweep_limit,
	output logic                          emit,
	output logic [$clog2(SLOTS)-1:0]      slot_cur
);

	localparam int SLOT_W = $clog2(SLOTS);
	localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(SLOTS - 1);

	logic [SLOT_W-1:0] slot_q;
	logic              down_q;
	logic              down_next;

	always_comb begin
		if (scan_angle >= sweep_limit) begin
			down_next = 1'b1;
		end else if (scan_angle == 8'd0) begin
			down_next = 1'b0;
		end else begin
			down_next = down_q;
		end
		emit     = frame_done && is_mult9(scan_angle);
		slot_cur = slot_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			down_q <= 1'b0;
		end else if (advance && frame_done) begin
			down_q <= down_next;
			if (emit) begin
				if (down_next) begin
					if (slot_q != '0) begin
						slot_q <= slot_q - 1'b1;
					end
				end else begin
					if (slot_q < SLOT_MAX) begin
						slot_q <= slot_q + 1'b1;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

[rtl/lidar_frame_parser_sweep_recorder.sv]
// an accepted word passes the input register, then the result register,
// before its result reaches the outputs
// throughput: one word per cycle; the input stage holds while a result waits
// reset: parser hunts the first header, slot 0 sweeping upward,
// sweep limit 90, no result pending
`default_nettype none
module lidar_frame_parser_sweep_recorder
	import lfp_pkg::*;
#(
	parameter int SLOTS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	input  wire logic [7:0]  scan_angle,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      distance,
	output logic [3:0]       slot,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data
);

	localparam int SLOT_W = $clog2(SLOTS);

	logic              valid_s1;
	logic [7:0]        rx_byte_s1;
	logic [7:0]        angle_s1;
	logic              advance;
	logic [7:0]        sweep_limit_q;
	frame_t            frame;
	logic              emit;
	logic [SLOT_W-1:0] slot_cur;
	logic              out_valid_q;
	logic [15:0]       distance_q;
	logic [3:0]        slot_q;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign distance  = distance_q;
	assign slot      = slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_limit_q <= LIMIT_RESET;
		end else if (cfg_valid) begin
			sweep_limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rx_byte_s1 <= rx_byte;
			angle_s1   <= scan_angle;
		end
	end

	lfp_frame_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.rx_byte (rx_byte_s1),
		.frame   (frame)
	);

	lfp_sweep #(
		.SLOTS (SLOTS)
	) u_sweep (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.frame_done  (frame.done),
		.scan_angle  (angle_s1),
		.sweep_limit (sweep_limit_q),
		.emit        (emit),
		.slot_cur    (slot_cur)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			distance_q <= frame.distance;
			slot_q     <= 4'(slot_cur);
		end
	end

endmodule
`default_nettype wire

[dv/lidar_frame_parser_sweep_recorder_tb.sv]
`timescale 1ns / 100ps
module lidar_frame_parser_sweep_recorder_tb;
	import lfp_pkg::*;

	localparam int SLOT_COUNT = 16;
	localparam int SETTLE_CYCLES = 6;
	localparam int TAIL_CYCLES = 10;
	localparam int QUIET_LIMIT = 4000;
	localparam int CALM_TAIL = 150;
	localparam int SHOW_LIMIT = 10;
	localparam int SEGMENT_WORDS = 145;

	typedef enum logic [1:0] {
		OP_BYTE,
		OP_LIMIT,
		OP_SETTLE
	} op_kind_e;

	typedef struct packed {
		op_kind_e   kind;
		logic [7:0] rx;
		logic [7:0] angle;
		logic [7:0] limit;
	} link_op_t;

	typedef struct packed {
		logic [15:0] distance;
		logic [3:0]  slot;
	} sweep_hit_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = 8'd0;
	logic [7:0]  scan_angle = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] distance;
	logic [3:0]  slot;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = 8'd0;

	link_op_t   ops[$];
	sweep_hit_t hits_due[$];

	phase_t     ph_m;
	logic [2:0] body_idx_m;
	logic [7:0] csum_m;
	logic [7:0] lo_m;
	logic [7:0] hi_m;
	int         slot_m;
	logic       down_m;
	logic [7:0] limit_m;

	int unsigned faults = 0;
	int unsigned bytes_taken = 0;
	int unsigned hits_seen = 0;
	int unsigned limits_set = 0;
	int unsigned quiet_cycles = 0;
	int          idle_left = 0;
	int          stall_left = 0;
	int          settle_cnt = 0;
	logic        stim_done = 1'b0;
	logic        calm = 1'b0;

	lidar_frame_parser_sweep_recorder #(
		.SLOTS(SLOT_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.scan_angle(scan_angle),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.distance(distance),
		.slot(slot),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic void model_reset();
		ph_m = PH_HUNT1;
		body_idx_m = 3'd0;
		csum_m = 8'd0;
		lo_m = 8'd0;
		hi_m = 8'd0;
		slot_m = 0;
		down_m = 1'b0;
		limit_m = LIMIT_RESET;
	endfunction

	function automatic void log_sweep_hit(input logic [7:0] angle);
		sweep_hit_t hit;
		if (angle >= limit_m)
			down_m = 1'b1;
		else if (angle == 8'd0)
			down_m = 1'b0;
		if (angle % 9 == 0) begin
			hit.distance = {hi_m, lo_m};
			hit.slot = 4'(slot_m);
			hits_due.push_back(hit);
			if (down_m) begin
				if (slot_m > 0)
					slot_m--;
			end else if (slot_m < SLOT_COUNT - 1) begin
				slot_m++;
			end
		end
	endfunction

	function automatic void parse_rx_byte(input logic [7:0] b, input logic [7:0] angle);
		logic good;
		case (ph_m)
			PH_HUNT1: begin
				if (b == HDR_BYTE) begin
					ph_m = PH_HUNT2;
					csum_m = HDR_BYTE;
				end
			end
			PH_HUNT2: begin
				if (b == HDR_BYTE) begin
					ph_m = PH_BODY;
					body_idx_m = 3'd0;
					csum_m = csum_m + HDR_BYTE;
				end else begin
					ph_m = PH_HUNT1;
					body_idx_m = 3'd0;
					csum_m = 8'd0;
				end
			end
			default: begin
				if (body_idx_m < BODY_LAST) begin
					if (body_idx_m == POS_LOW)
						lo_m = b;
					else if (body_idx_m == POS_HIGH)
						hi_m = b;
					csum_m = csum_m + b;
					body_idx_m = body_idx_m + 3'd1;
				end else begin
					good = (b == csum_m);
					ph_m = PH_HUNT1;
					body_idx_m = 3'd0;
					csum_m = 8'd0;
					if (good)
						log_sweep_hit(angle);
				end
			end
		endcase
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic [7:0] angle);
		link_op_t op;
		op.kind = OP_BYTE;
		op.rx = b;
		op.angle = angle;
		op.limit = 8'd0;
		ops.push_back(op);
	endtask

	task automatic push_settle();
		link_op_t op;
		op.kind = OP_SETTLE;
		op.rx = 8'd0;
		op.angle = 8'd0;
		op.limit = 8'd0;
		ops.push_back(op);
	endtask

	task automatic push_limit(input logic [7:0] value);
		link_op_t op;
		push_settle();
		op.kind = OP_LIMIT;
		op.rx = 8'd0;
		op.angle = 8'd0;
		op.limit = value;
		ops.push_back(op);
	endtask

	task automatic push_frame(input logic [7:0] lo, input logic [7:0] hi,
			input logic [7:0] angle, input logic bad_sum);
		logic [7:0] sum;
		logic [7:0] b;
		push_byte(HDR_BYTE, 8'($urandom_range(0, 255)));
		push_byte(HDR_BYTE, 8'($urandom_range(0, 255)));
		sum = HDR_BYTE + HDR_BYTE + lo + hi;
		push_byte(lo, 8'($urandom_range(0, 255)));
		push_byte(hi, 8'($urandom_range(0, 255)));
		for (int i = 0; i < 4; i++) begin
			b = 8'($urandom_range(0, 255));
			sum = sum + b;
			push_byte(b, 8'($urandom_range(0, 255)));
		end
		if (bad_sum)
			sum = sum + 8'($urandom_range(1, 255));
		push_byte(sum, angle);
	endtask

	function automatic logic [7:0] pick_angle();
		if ($urandom_range(0, 3) != 0)
			return 8'(9 * $urandom_range(0, 28));
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic random_traffic(input int words);
		int start;
		int pick;
		int n;
		start = ops.size();
		while (ops.size() - start < words) begin
			pick = $urandom_range(0, 9);
			if (pick <= 6) begin
				push_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					pick_angle(), 1'b0);
			end else if (pick == 7) begin
				push_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					pick_angle(), 1'b1);
			end else if (pick == 8) begin
				n = $urandom_range(1, 5);
				for (int i = 0; i < n; i++)
					push_byte($urandom_range(0, 3) == 0 ? HDR_BYTE : 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)));
			end else begin
				push_byte(HDR_BYTE, 8'($urandom_range(0, 255)));
				if ($urandom_range(0, 1) == 0) begin
					push_byte(8'($urandom_range(0, 88)), 8'($urandom_range(0, 255)));
				end else begin
					push_byte(HDR_BYTE, 8'($urandom_range(0, 255)));
					n = $urandom_range(1, 5);
					for (int i = 0; i < n; i++)
						push_byte(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : drive_link
		logic       nxt_in_valid;
		logic       nxt_cfg_valid;
		logic [7:0] nxt_rx;
		logic [7:0] nxt_angle;
		logic [7:0] nxt_cfg;
		link_op_t   cur;
		if (!arst_n) begin
			in_valid <= 1'b0;
			cfg_valid <= 1'b0;
			rx_byte <= 8'd0;
			scan_angle <= 8'd0;
			cfg_data <= 8'd0;
			model_reset();
			idle_left = 0;
			settle_cnt = 0;
			stim_done = 1'b0;
		end else begin
			nxt_in_valid = in_valid;
			nxt_cfg_valid = cfg_valid;
			nxt_rx = rx_byte;
			nxt_angle = scan_angle;
			nxt_cfg = cfg_data;
			if (in_valid && in_ready) begin
				parse_rx_byte(rx_byte, scan_angle);
				bytes_taken++;
				nxt_in_valid = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				limit_m = cfg_data;
				limits_set++;
				nxt_cfg_valid = 1'b0;
			end
			calm = ops.size() < CALM_TAIL;
			if (!nxt_in_valid && !nxt_cfg_valid) begin
				if (idle_left > 0) begin
					idle_left--;
				end else if (ops.size() == 0) begin
					stim_done = 1'b1;
				end else begin
					cur = ops[0];
					case (cur.kind)
						OP_BYTE: begin
							nxt_in_valid = 1'b1;
							nxt_rx = cur.rx;
							nxt_angle = cur.angle;
							cur = ops.pop_front();
							if (!calm && $urandom_range(0, 5) == 0)
								idle_left = $urandom_range(1, 9);
						end
						OP_LIMIT: begin
							nxt_cfg_valid = 1'b1;
							nxt_cfg = cur.limit;
							cur = ops.pop_front();
						end
						default: begin
							if (hits_due.size() == 0)
								settle_cnt++;
							else
								settle_cnt = 0;
							if (settle_cnt >= SETTLE_CYCLES) begin
								settle_cnt = 0;
								cur = ops.pop_front();
							end
						end
					endcase
				end
			end
			in_valid <= nxt_in_valid;
			rx_byte <= nxt_rx;
			scan_angle <= nxt_angle;
			cfg_valid <= nxt_cfg_valid;
			cfg_data <= nxt_cfg;
		end
	end

	always @(posedge clk or negedge arst_n) begin : watch_result
		sweep_hit_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				hits_seen++;
				if (hits_due.size() == 0) begin
					faults++;
					if (faults <= SHOW_LIMIT)
						$display("unexpected word: distance %0d slot %0d", distance, slot);
				end else begin
					want = hits_due.pop_front();
					if (distance !== want.distance || slot !== want.slot) begin
						faults++;
						if (faults <= SHOW_LIMIT)
							$display("mismatch: expected distance %0d slot %0d, got distance %0d slot %0d",
								want.distance, want.slot, distance, slot);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 8);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		// failed second header, then edge distances and a dropped frame
		push_byte(HDR_BYTE, 8'd0);
		push_byte(8'hA6, 8'd255);
		push_frame(8'h00, 8'h00, 8'd0, 1'b0);
		push_frame(8'hFF, 8'hFF, 8'd180, 1'b0);
		push_frame(8'h34, 8'h12, 8'd9, 1'b1);

		push_limit(8'd1);
		random_traffic(SEGMENT_WORDS);
		push_limit(8'd180);
		random_traffic(SEGMENT_WORDS);
		push_limit(8'd0);
		random_traffic(SEGMENT_WORDS / 2);
		push_settle();
		random_traffic(SEGMENT_WORDS / 2);
		push_limit(8'd255);
		random_traffic(SEGMENT_WORDS);
		push_limit(8'($urandom_range(1, 180)));
		random_traffic(SEGMENT_WORDS);
		push_limit(LIMIT_RESET);
		random_traffic(SEGMENT_WORDS);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (!(stim_done && hits_due.size() == 0) && quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		if (quiet_cycles >= QUIET_LIMIT) begin
			faults++;
			$display("timeout: no handshake for %0d cycles", quiet_cycles);
		end else begin
			repeat (TAIL_CYCLES) @(posedge clk);
		end
		if (hits_due.size() != 0) begin
			faults += hits_due.size();
			$display("%0d expected words never arrived", hits_due.size());
		end

		$display("%0d bytes parsed, %0d sweep words checked, %0d limit writes",
			bytes_taken, hits_seen, limits_set);
		$display("%0d faults", faults);
		if (faults == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
